@@ rtl/oasp_pkg.sv @@
package oasp_pkg;

   localparam int ANGLE_STEPS_DEF = 1024;
   localparam int ANGLE_W         = 10;
   localparam int ANGLE_CODES     = 1 << ANGLE_W;
   localparam int PW              = 52;
   localparam int BW              = 48;
   localparam int AXIS_ONE        = 16384;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

   typedef enum logic [1:0] {
      AXIS_BOX_X   = 2'd0,
      AXIS_BOX_Y   = 2'd1,
      AXIS_WORLD_X = 2'd2,
      AXIS_WORLD_Y = 2'd3
   } axis_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [9:0]         angle_code;
      logic [11:0]        half_width;
      logic [11:0]        half_height;
      logic signed [15:0] wall_x;
      logic signed [15:0] wall_y;
      logic [15:0]        wall_width;
      logic [15:0]        wall_height;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] sin_v;
      logic signed [15:0] cos_v;
   } keep_type;

   typedef struct packed {
      logic signed [PW-1:0] ov;
      logic                 sgn;
   } axov_type;

   typedef struct packed {
      logic          collided;
      axis_type      axis;
      logic          sgn;
      logic [BW-1:0] best;
      keep_type      keep;
   } pick_type;

   // Q32 turn fraction in, Q1.14 sine out; evaluated at elaboration only
   function automatic logic signed [15:0] sin_turn(input logic [31:0] t_in);
      logic        neg;
      logic [31:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] q;
      neg = t_in[31];
      t = {1'b0, t_in[30:0]};
      if (t > 32'h4000_0000) begin
         t = 32'h8000_0000 - t;
      end
      x  = (64'(t) * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      r  = Q30_ONE;
      r  = Q30_ONE - ((x2 * r) >> 30) / 156;
      r  = Q30_ONE - ((x2 * r) >> 30) / 110;
      r  = Q30_ONE - ((x2 * r) >> 30) / 72;
      r  = Q30_ONE - ((x2 * r) >> 30) / 42;
      r  = Q30_ONE - ((x2 * r) >> 30) / 20;
      r  = Q30_ONE - ((x2 * r) >> 30) / 6;
      s  = (x * r) >> 30;
      q  = (s + (64'd1 << 15)) >> 16;
      if (q > 64'd16384) begin
         q = 64'd16384;
      end
      return neg ? -$signed(q[15:0]) : $signed(q[15:0]);
   endfunction

endpackage

@@ rtl/obb_aabb_sat_push_out_unit.sv @@
// Oriented box against axis-aligned wall, separating axis push-out.
// Input: a beat is taken on a rising edge with start high and busy low.
// busy is held low, so a new beat may be offered every cycle.
// req_ ports carry the box centre, heading code, half extents and the
// wall rectangle, all raw fixed-point codes.
// Output: rsp_valid is high for one cycle per beat with the pushed
// centre, collided flag, winning axis and push depth on the rsp_ ports.
// Throughput is one beat per cycle through the 13-stage pipeline
// (sine/cosine table read, six projection stages, two selection rounds,
// four push stages with the depth product split in two halves).
// Results leave in the order the beats came in.
// The receiver cannot hold results off; none is needed, as the pipe
// never stalls.
// Reset clears every valid bit; beats in flight are dropped.
module obb_aabb_sat_push_out_unit #(
   parameter int ANGLE_STEPS = oasp_pkg::ANGLE_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [9:0]         req_angle_code,
   input  logic [11:0]        req_half_width,
   input  logic [11:0]        req_half_height,
   input  logic signed [15:0] req_wall_x,
   input  logic signed [15:0] req_wall_y,
   input  logic [15:0]        req_wall_width,
   input  logic [15:0]        req_wall_height,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_new_x,
   output logic signed [15:0] rsp_new_y,
   output logic               rsp_collided,
   output logic [1:0]         rsp_min_axis,
   output logic [15:0]        rsp_push_depth
);

   logic               v0_ff, v0_in;
   oasp_pkg::req_type  req0_ff, req0_in;
   logic signed [15:0] sin_val, cos_val;
   logic               pv;
   oasp_pkg::axov_type axov [4];
   oasp_pkg::keep_type keep;
   logic               sv;
   oasp_pkg::pick_type pick;

   assign busy  = 1'b0;
   assign v0_in = start && !busy;
   assign req0_in = '{
      pos_x:       req_pos_x,
      pos_y:       req_pos_y,
      angle_code:  req_angle_code,
      half_width:  req_half_width,
      half_height: req_half_height,
      wall_x:      req_wall_x,
      wall_y:      req_wall_y,
      wall_width:  req_wall_width,
      wall_height: req_wall_height
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
      end
      req0_ff <= req0_in;
   end

   oasp_trig #(
      .ANGLE_STEPS(ANGLE_STEPS)
   ) u_trig (
      .clock   (clock),
      .angle   (req_angle_code),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   oasp_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .req       (req0_ff),
      .sin_val   (sin_val),
      .cos_val   (cos_val),
      .out_valid (pv),
      .axov      (axov),
      .keep      (keep)
   );

   oasp_sel u_sel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv),
      .axov      (axov),
      .keep      (keep),
      .out_valid (sv),
      .pick      (pick)
   );

   oasp_push u_push (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sv),
      .pick       (pick),
      .out_valid  (rsp_valid),
      .new_x      (rsp_new_x),
      .new_y      (rsp_new_y),
      .collided   (rsp_collided),
      .min_axis   (rsp_min_axis),
      .push_depth (rsp_push_depth)
   );

endmodule

@@ rtl/oasp_trig.sv @@
module oasp_trig #(
   parameter int ANGLE_STEPS = oasp_pkg::ANGLE_STEPS_DEF
) (
   input  logic                              clock,
   input  logic [oasp_pkg::ANGLE_W-1:0]      angle,
   output logic signed [15:0]                sin_val,
   output logic signed [15:0]                cos_val
);

   logic signed [15:0] sin_tab [oasp_pkg::ANGLE_CODES];
   logic signed [15:0] cos_tab [oasp_pkg::ANGLE_CODES];
   logic signed [15:0] sin_ff;
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_in;
   logic signed [15:0] cos_in;

   for (genvar g = 0; g < oasp_pkg::ANGLE_CODES; g++) begin : g_tab
      localparam longint unsigned K  = longint'(g % ANGLE_STEPS);
      localparam longint unsigned PH = (K << 32) / longint'(ANGLE_STEPS);
      localparam logic [31:0] T = PH[31:0];
      localparam logic signed [15:0] SV = oasp_pkg::sin_turn(T);
      localparam logic signed [15:0] CV = oasp_pkg::sin_turn(T + 32'h4000_0000);
      assign sin_tab[g] = SV;
      assign cos_tab[g] = CV;
   end

   assign sin_in = sin_tab[angle];
   assign cos_in = cos_tab[angle];

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

@@ rtl/oasp_proj.sv @@
module oasp_proj (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  oasp_pkg::req_type  req,
   input  logic signed [15:0] sin_val,
   input  logic signed [15:0] cos_val,
   output logic               out_valid,
   output oasp_pkg::axov_type axov [4],
   output oasp_pkg::keep_type keep
);

   localparam int PW = oasp_pkg::PW;

   // stage 1: products
   logic               v1_ff, v1_in;
   oasp_pkg::req_type  req1_ff;
   oasp_pkg::keep_type keep1_ff, keep1_in;
   logic signed [31:0] pxc_ff, pys_ff, pxs_ff, pyc_ff, pxc_in, pys_in, pxs_in, pyc_in;
   logic signed [31:0] wxc_ff, wys_ff, wxs_ff, wyc_ff, wxc_in, wys_in, wxs_in, wyc_in;
   logic signed [32:0] wwc_ff, whs_ff, wws_ff, whc_ff, wwc_in, whs_in, wws_in, whc_in;
   logic [28:0]        cc_ff, ss_ff, cc_in, ss_in;
   logic [26:0]        hwac_ff, hhas_ff, hwas_ff, hhac_ff;
   logic [26:0]        hwac_in, hhas_in, hwas_in, hhac_in;
   logic signed [31:0] csq, ssq;
   logic signed [15:0] cabs, sabs;

   assign v1_in    = in_valid;
   assign keep1_in = '{pos_x: req.pos_x, pos_y: req.pos_y, sin_v: sin_val, cos_v: cos_val};
   assign pxc_in = req.pos_x * cos_val;
   assign pys_in = req.pos_y * sin_val;
   assign pxs_in = req.pos_x * sin_val;
   assign pyc_in = req.pos_y * cos_val;
   assign wxc_in = req.wall_x * cos_val;
   assign wys_in = req.wall_y * sin_val;
   assign wxs_in = req.wall_x * sin_val;
   assign wyc_in = req.wall_y * cos_val;
   assign wwc_in = $signed({1'b0, req.wall_width}) * cos_val;
   assign whs_in = $signed({1'b0, req.wall_height}) * sin_val;
   assign wws_in = $signed({1'b0, req.wall_width}) * sin_val;
   assign whc_in = $signed({1'b0, req.wall_height}) * cos_val;
   assign csq    = cos_val * cos_val;
   assign ssq    = sin_val * sin_val;
   assign cc_in  = csq[28:0];
   assign ss_in  = ssq[28:0];
   assign cabs   = cos_val[15] ? -cos_val : cos_val;
   assign sabs   = sin_val[15] ? -sin_val : sin_val;
   assign hwac_in = req.half_width * cabs[14:0];
   assign hhas_in = req.half_height * sabs[14:0];
   assign hwas_in = req.half_width * sabs[14:0];
   assign hhac_in = req.half_height * cabs[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      req1_ff  <= req;
      keep1_ff <= keep1_in;
      pxc_ff <= pxc_in;  pys_ff <= pys_in;  pxs_ff <= pxs_in;  pyc_ff <= pyc_in;
      wxc_ff <= wxc_in;  wys_ff <= wys_in;  wxs_ff <= wxs_in;  wyc_ff <= wyc_in;
      wwc_ff <= wwc_in;  whs_ff <= whs_in;  wws_ff <= wws_in;  whc_ff <= whc_in;
      cc_ff  <= cc_in;   ss_ff  <= ss_in;
      hwac_ff <= hwac_in; hhas_ff <= hhas_in; hwas_ff <= hwas_in; hhac_ff <= hhac_in;
   end

   // stage 2: sums
   logic               v2_ff;
   oasp_pkg::req_type  req2_ff;
   oasp_pkg::keep_type keep2_ff;
   logic [29:0]        m_ff, m_in;
   logic signed [32:0] a0_ff, a1_ff, w0_ff, w1_ff, a0_in, a1_in, w0_in, w1_in;
   logic signed [33:0] n0_ff, x0_ff, n1_ff, x1_ff, n0_in, x0_in, n1_in, x1_in;
   logic [27:0]        e2_ff, e3_ff, e2_in, e3_in;
   logic signed [33:0] nws, hc34, wc34, hs34;

   assign m_in  = 30'(cc_ff) + 30'(ss_ff);
   assign a0_in = 33'(pxc_ff) + 33'(pys_ff);
   assign a1_in = 33'(pyc_ff) - 33'(pxs_ff);
   assign w0_in = 33'(wxc_ff) + 33'(wys_ff);
   assign w1_in = 33'(wyc_ff) - 33'(wxs_ff);
   assign wc34  = 34'(wwc_ff);
   assign hs34  = 34'(whs_ff);
   assign nws   = -34'(wws_ff);
   assign hc34  = 34'(whc_ff);
   assign n0_in = (wc34[33] ? wc34 : 34'sd0) + (hs34[33] ? hs34 : 34'sd0);
   assign x0_in = (wc34[33] ? 34'sd0 : wc34) + (hs34[33] ? 34'sd0 : hs34);
   assign n1_in = (nws[33] ? nws : 34'sd0) + (hc34[33] ? hc34 : 34'sd0);
   assign x1_in = (nws[33] ? 34'sd0 : nws) + (hc34[33] ? 34'sd0 : hc34);
   assign e2_in = 28'(hwac_ff) + 28'(hhas_ff);
   assign e3_in = 28'(hwas_ff) + 28'(hhac_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      req2_ff  <= req1_ff;
      keep2_ff <= keep1_ff;
      m_ff  <= m_in;
      a0_ff <= a0_in;  a1_ff <= a1_in;  w0_ff <= w0_in;  w1_ff <= w1_in;
      n0_ff <= n0_in;  x0_ff <= x0_in;  n1_ff <= n1_in;  x1_ff <= x1_in;
      e2_ff <= e2_in;  e3_ff <= e3_in;
   end

   // stage 3: box extents, centres and wall bounds, all at 2^-28 codes
   logic               v3_ff;
   oasp_pkg::keep_type keep3_ff;
   logic signed [PW-1:0] ctr_ff [4], ext_ff [4], wmn3_ff [4], wmx3_ff [4];
   logic signed [PW-1:0] ctr_in [4], ext_in [4], wmn3_in [4], wmx3_in [4];
   logic [41:0]          bext0, bext1;

   assign bext0 = req2_ff.half_width * m_ff;
   assign bext1 = req2_ff.half_height * m_ff;

   always_comb begin
      ctr_in[0]  = PW'(a0_ff) <<< 14;
      ext_in[0]  = $signed(PW'(bext0));
      wmn3_in[0] = (PW'(w0_ff) + PW'(n0_ff)) <<< 14;
      wmx3_in[0] = (PW'(w0_ff) + PW'(x0_ff)) <<< 14;
      ctr_in[1]  = PW'(a1_ff) <<< 14;
      ext_in[1]  = $signed(PW'(bext1));
      wmn3_in[1] = (PW'(w1_ff) + PW'(n1_ff)) <<< 14;
      wmx3_in[1] = (PW'(w1_ff) + PW'(x1_ff)) <<< 14;
      ctr_in[2]  = PW'(req2_ff.pos_x) <<< 28;
      ext_in[2]  = $signed(PW'(e2_ff) << 14);
      wmn3_in[2] = PW'(req2_ff.wall_x) <<< 28;
      wmx3_in[2] = (PW'(req2_ff.wall_x) + $signed(PW'(req2_ff.wall_width))) <<< 28;
      ctr_in[3]  = PW'(req2_ff.pos_y) <<< 28;
      ext_in[3]  = $signed(PW'(e3_ff) << 14);
      wmn3_in[3] = PW'(req2_ff.wall_y) <<< 28;
      wmx3_in[3] = (PW'(req2_ff.wall_y) + $signed(PW'(req2_ff.wall_height))) <<< 28;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      keep3_ff <= keep2_ff;
      ctr_ff   <= ctr_in;
      ext_ff   <= ext_in;
      wmn3_ff  <= wmn3_in;
      wmx3_ff  <= wmx3_in;
   end

   // stage 4: box bounds
   logic               v4_ff;
   oasp_pkg::keep_type keep4_ff;
   logic signed [PW-1:0] cmn_ff [4], cmx_ff [4], wmn4_ff [4], wmx4_ff [4];
   logic signed [PW-1:0] cmn_in [4], cmx_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cmn_in[i] = ctr_ff[i] - ext_ff[i];
         cmx_in[i] = ctr_ff[i] + ext_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      keep4_ff <= keep3_ff;
      cmn_ff   <= cmn_in;
      cmx_ff   <= cmx_in;
      wmn4_ff  <= wmn3_ff;
      wmx4_ff  <= wmx3_ff;
   end

   // stage 5: overlap candidates and middle sums
   logic               v5_ff;
   oasp_pkg::keep_type keep5_ff;
   logic signed [PW-1:0] d1_ff [4], d2_ff [4], sc_ff [4], sw_ff [4];
   logic signed [PW-1:0] d1_in [4], d2_in [4], sc_in [4], sw_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         d1_in[i] = cmx_ff[i] - wmn4_ff[i];
         d2_in[i] = wmx4_ff[i] - cmn_ff[i];
         sc_in[i] = cmn_ff[i] + cmx_ff[i];
         sw_in[i] = wmn4_ff[i] + wmx4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      keep5_ff <= keep4_ff;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      sc_ff <= sc_in;
      sw_ff <= sw_in;
   end

   // stage 6: overlap per axis and push direction
   logic               v6_ff;
   oasp_pkg::keep_type keep6_ff;
   oasp_pkg::axov_type axov_ff [4], axov_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         axov_in[i].ov  = (d2_ff[i] < d1_ff[i]) ? d2_ff[i] : d1_ff[i];
         axov_in[i].sgn = sc_ff[i] > sw_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      keep6_ff <= keep5_ff;
      axov_ff  <= axov_in;
   end

   assign out_valid = v6_ff;
   assign axov      = axov_ff;
   assign keep      = keep6_ff;

endmodule

@@ rtl/oasp_sel.sv @@
module oasp_sel (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  oasp_pkg::axov_type axov [4],
   input  oasp_pkg::keep_type keep,
   output logic               out_valid,
   output oasp_pkg::pick_type pick
);

   localparam int PW = oasp_pkg::PW;
   localparam int BW = oasp_pkg::BW;

   // round 1: pairs, earlier axis kept on a tie
   logic                 v1_ff;
   oasp_pkg::keep_type   keep1_ff;
   logic                 coll_ff, coll_in;
   logic signed [PW-1:0] ova_ff, ovb_ff, ova_in, ovb_in;
   oasp_pkg::axis_type   axa_ff, axb_ff, axa_in, axb_in;
   logic                 sga_ff, sgb_ff, sga_in, sgb_in;
   logic                 take1, take3;

   assign coll_in = (axov[0].ov > 0) && (axov[1].ov > 0) && (axov[2].ov > 0)
                 && (axov[3].ov > 0);
   assign take1   = axov[1].ov < axov[0].ov;
   assign take3   = axov[3].ov < axov[2].ov;
   assign ova_in  = take1 ? axov[1].ov : axov[0].ov;
   assign sga_in  = take1 ? axov[1].sgn : axov[0].sgn;
   assign axa_in  = take1 ? oasp_pkg::AXIS_BOX_Y : oasp_pkg::AXIS_BOX_X;
   assign ovb_in  = take3 ? axov[3].ov : axov[2].ov;
   assign sgb_in  = take3 ? axov[3].sgn : axov[2].sgn;
   assign axb_in  = take3 ? oasp_pkg::AXIS_WORLD_Y : oasp_pkg::AXIS_WORLD_X;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      keep1_ff <= keep;
      coll_ff  <= coll_in;
      ova_ff <= ova_in;  ovb_ff <= ovb_in;
      axa_ff <= axa_in;  axb_ff <= axb_in;
      sga_ff <= sga_in;  sgb_ff <= sgb_in;
   end

   // round 2: final
   logic               v2_ff;
   oasp_pkg::pick_type pick_ff, pick_in;
   logic               takeb;

   assign takeb            = ovb_ff < ova_ff;
   assign pick_in.collided = coll_ff;
   assign pick_in.axis     = takeb ? axb_ff : axa_ff;
   assign pick_in.sgn      = takeb ? sgb_ff : sga_ff;
   assign pick_in.best     = takeb ? ovb_ff[BW-1:0] : ova_ff[BW-1:0];
   assign pick_in.keep     = keep1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pick_ff <= pick_in;
   end

   assign out_valid = v2_ff;
   assign pick      = pick_ff;

endmodule

@@ rtl/oasp_push.sv @@
module oasp_push (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  oasp_pkg::pick_type pick,
   output logic               out_valid,
   output logic signed [15:0] new_x,
   output logic signed [15:0] new_y,
   output logic               collided,
   output logic [1:0]         min_axis,
   output logic [15:0]        push_depth
);

   localparam int BW = oasp_pkg::BW;
   localparam int HB = BW / 2;

   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      if (v > 25'sd32767) begin
         return 16'sh7fff;
      end else if (v < -25'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // step 1: signed axis components, depth rounding
   logic               v1_ff;
   oasp_pkg::pick_type pick1_ff;
   logic signed [15:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [15:0] ux, uy;
   logic [15:0]        dep_ff, dep_in;
   logic [BW-28:0]     dr;

   always_comb begin
      case (pick.axis)
         oasp_pkg::AXIS_BOX_X: begin
            ux = pick.keep.cos_v;
            uy = pick.keep.sin_v;
         end
         oasp_pkg::AXIS_BOX_Y: begin
            ux = -pick.keep.sin_v;
            uy = pick.keep.cos_v;
         end
         oasp_pkg::AXIS_WORLD_X: begin
            ux = 16'(oasp_pkg::AXIS_ONE);
            uy = 16'sd0;
         end
         oasp_pkg::AXIS_WORLD_Y: begin
            ux = 16'sd0;
            uy = 16'(oasp_pkg::AXIS_ONE);
         end
         default: begin
            ux = 16'sd0;
            uy = 16'sd0;
         end
      endcase
   end

   assign cx_in  = pick.sgn ? ux : -ux;
   assign cy_in  = pick.sgn ? uy : -uy;
   assign dr     = (BW-27)'((pick.best + (BW'(1) << 27)) >> 28);
   assign dep_in = (dr > (BW-27)'(16'hffff)) ? 16'hffff : dr[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      pick1_ff <= pick;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      dep_ff   <= dep_in;
   end

   // step 2: partial products over the two halves of the depth
   logic               v2_ff;
   oasp_pkg::pick_type pick2_ff;
   logic [15:0]        dep2_ff;
   logic signed [HB+16:0] plx_ff, phx_ff, ply_ff, phy_ff;
   logic signed [HB+16:0] plx_in, phx_in, ply_in, phy_in;

   assign plx_in = cx_ff * $signed({1'b0, pick1_ff.best[HB-1:0]});
   assign phx_in = cx_ff * $signed({1'b0, pick1_ff.best[BW-1:HB]});
   assign ply_in = cy_ff * $signed({1'b0, pick1_ff.best[HB-1:0]});
   assign phy_in = cy_ff * $signed({1'b0, pick1_ff.best[BW-1:HB]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pick2_ff <= pick1_ff;
      dep2_ff  <= dep_ff;
      plx_ff <= plx_in;  phx_ff <= phx_in;  ply_ff <= ply_in;  phy_ff <= phy_in;
   end

   // step 3: recombine, round half up at 2^-42
   logic               v3_ff;
   oasp_pkg::pick_type pick3_ff;
   logic [15:0]        dep3_ff;
   logic signed [65:0] vx, vy;
   logic signed [23:0] dx_ff, dy_ff, dx_in, dy_in;

   assign vx    = (66'(phx_ff) <<< HB) + 66'(plx_ff) + (66'sd1 <<< 41);
   assign vy    = (66'(phy_ff) <<< HB) + 66'(ply_ff) + (66'sd1 <<< 41);
   assign dx_in = vx[65:42];
   assign dy_in = vy[65:42];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      pick3_ff <= pick2_ff;
      dep3_ff  <= dep2_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
   end

   // step 4: apply and saturate
   logic               v4_ff;
   logic signed [15:0] nx_ff, ny_ff, nx_in, ny_in;
   logic               col_ff;
   logic [1:0]         ax_ff, ax_in;
   logic [15:0]        dep4_ff, dep4_in;
   logic signed [24:0] sx, sy;

   assign sx      = 25'(pick3_ff.keep.pos_x) + 25'(dx_ff);
   assign sy      = 25'(pick3_ff.keep.pos_y) + 25'(dy_ff);
   assign nx_in   = pick3_ff.collided ? sat16(sx) : pick3_ff.keep.pos_x;
   assign ny_in   = pick3_ff.collided ? sat16(sy) : pick3_ff.keep.pos_y;
   assign ax_in   = pick3_ff.collided ? pick3_ff.axis : oasp_pkg::AXIS_BOX_X;
   assign dep4_in = pick3_ff.collided ? dep3_ff : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      col_ff  <= pick3_ff.collided;
      ax_ff   <= ax_in;
      dep4_ff <= dep4_in;
   end

   assign out_valid  = v4_ff;
   assign new_x      = nx_ff;
   assign new_y      = ny_ff;
   assign collided   = col_ff;
   assign min_axis   = ax_ff;
   assign push_depth = dep4_ff;

endmodule

@@ sim/tb_obb_aabb_sat_push_out_unit.sv @@
module tb_obb_aabb_sat_push_out_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1450;
   localparam int LATENCY  = 13;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [15:0]   new_x;
      logic signed [15:0]   new_y;
      logic                 collided;
      oasp_pkg::axis_type   min_axis;
      logic [15:0]          push_depth;
   } push_out_type;

   typedef longint corner_type [4];

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] req_pos_x, req_pos_y, req_wall_x, req_wall_y;
   logic [9:0]  req_angle_code;
   logic [11:0] req_half_width, req_half_height;
   logic [15:0] req_wall_width, req_wall_height;
   logic        rsp_valid;
   logic signed [15:0] rsp_new_x, rsp_new_y;
   logic        rsp_collided;
   logic [1:0]  rsp_min_axis;
   logic [15:0] rsp_push_depth;

   oasp_pkg::req_type query_q[$];
   push_out_type      push_q[$];
   oasp_pkg::req_type cur;
   int  gap, sent, got, errors, n_directed, stall, n_hit;
   int  axis_seen [4];
   bit  burst;

   obb_aabb_sat_push_out_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_angle_code(req_angle_code),
      .req_half_width(req_half_width), .req_half_height(req_half_height),
      .req_wall_x(req_wall_x), .req_wall_y(req_wall_y),
      .req_wall_width(req_wall_width), .req_wall_height(req_wall_height),
      .rsp_valid(rsp_valid), .rsp_new_x(rsp_new_x), .rsp_new_y(rsp_new_y),
      .rsp_collided(rsp_collided), .rsp_min_axis(rsp_min_axis),
      .rsp_push_depth(rsp_push_depth)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Q32 turn phase to Q1.14 sine, truncating odd series to x^13
   function automatic longint q14_sine(input logic [31:0] phase);
      logic [63:0] h, x, x2, r, s, q;
      longint divs [6];
      divs = '{156, 110, 72, 42, 20, 6};
      h = {33'd0, phase[30:0]};
      if (h > 64'h4000_0000) begin
         h = 64'h8000_0000 - h;
      end
      x  = (h * 64'd6746518852) >> 32;
      x2 = (x * x) >> 30;
      r  = 64'd1 << 30;
      for (int i = 0; i < 6; i++) begin
         r = (64'd1 << 30) - ((x2 * r) >> 30) / 64'(divs[i]);
      end
      s = (x * r) >> 30;
      q = (s + (64'd1 << 15)) >> 16;
      if (q > 64'd16384) begin
         q = 64'd16384;
      end
      return phase[31] ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint round_half_up(input longint v, input int n);
      logic [63:0] u;
      u = 64'(v) + (64'd1 << 62);
      u = (u + (64'd1 << (n - 1))) >> n;
      return longint'(u) - longint'((64'd1 << 62) >> n);
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'sd32767;
      end
      if (v < -32768) begin
         return -16'sd32768;
      end
      return v[15:0];
   endfunction

   function automatic void span(input corner_type xs, input corner_type ys,
                                input longint ax, input longint ay,
                                output longint lo, output longint hi);
      longint p;
      lo = xs[0] * ax + ys[0] * ay;
      hi = lo;
      for (int i = 1; i < 4; i++) begin
         p = xs[i] * ax + ys[i] * ay;
         if (p < lo) lo = p;
         if (p > hi) hi = p;
      end
   endfunction

   function automatic push_out_type push_out(input oasp_pkg::req_type r);
      push_out_type o;
      corner_type bx, by, gx, gy;
      longint ax [4];
      longint ay [4];
      longint px, py, hw, hh, wx, wy, ww, wh, s, c;
      longint cmn, cmx, wmn, wmx, ov, best, bsign, d;
      int sx [4];
      int sy [4];
      int baxis;
      logic [31:0] t;
      sx = '{-1, 1, 1, -1};
      sy = '{-1, -1, 1, 1};
      px = r.pos_x;
      py = r.pos_y;
      hw = longint'({1'b0, r.half_width});
      hh = longint'({1'b0, r.half_height});
      wx = r.wall_x;
      wy = r.wall_y;
      ww = longint'({1'b0, r.wall_width});
      wh = longint'({1'b0, r.wall_height});
      t  = {r.angle_code, 22'd0};
      s  = q14_sine(t);
      c  = q14_sine(t + 32'h4000_0000);
      for (int i = 0; i < 4; i++) begin
         bx[i] = px * oasp_pkg::AXIS_ONE + sx[i] * hw * c - sy[i] * hh * s;
         by[i] = py * oasp_pkg::AXIS_ONE + sx[i] * hw * s + sy[i] * hh * c;
      end
      gx = '{wx * oasp_pkg::AXIS_ONE, (wx + ww) * oasp_pkg::AXIS_ONE,
             (wx + ww) * oasp_pkg::AXIS_ONE, wx * oasp_pkg::AXIS_ONE};
      gy = '{wy * oasp_pkg::AXIS_ONE, wy * oasp_pkg::AXIS_ONE,
             (wy + wh) * oasp_pkg::AXIS_ONE, (wy + wh) * oasp_pkg::AXIS_ONE};
      ax = '{c, -s, oasp_pkg::AXIS_ONE, 0};
      ay = '{s, c, 0, oasp_pkg::AXIS_ONE};
      best = 0;
      bsign = -1;
      baxis = 0;
      o.new_x = r.pos_x;
      o.new_y = r.pos_y;
      o.collided = 1'b0;
      o.min_axis = oasp_pkg::AXIS_BOX_X;
      o.push_depth = '0;
      for (int a = 0; a < 4; a++) begin
         span(bx, by, ax[a], ay[a], cmn, cmx);
         span(gx, gy, ax[a], ay[a], wmn, wmx);
         ov = cmx - wmn;
         if (wmx - cmn < ov) ov = wmx - cmn;
         if (ov <= 0) begin
            return o;
         end
         if (a == 0 || ov < best) begin
            best = ov;
            baxis = a;
            bsign = (cmn + cmx > wmn + wmx) ? 1 : -1;
         end
      end
      d = round_half_up(best, 28);
      o.new_x = clamp16(px + round_half_up(bsign * ax[baxis] * best, 42));
      o.new_y = clamp16(py + round_half_up(bsign * ay[baxis] * best, 42));
      o.collided = 1'b1;
      o.min_axis = oasp_pkg::axis_type'(baxis);
      o.push_depth = (d > 65535) ? 16'hFFFF : d[15:0];
      return o;
   endfunction

   task automatic add_query(input int px, input int py, input int ang, input int hw,
                            input int hh, input int wx, input int wy, input int ww,
                            input int wh);
      oasp_pkg::req_type r;
      r.pos_x = px[15:0];
      r.pos_y = py[15:0];
      r.angle_code = ang[9:0];
      r.half_width = hw[11:0];
      r.half_height = hh[11:0];
      r.wall_x = wx[15:0];
      r.wall_y = wy[15:0];
      r.wall_width = ww[15:0];
      r.wall_height = wh[15:0];
      query_q.push_back(r);
   endtask

   task automatic add_random_query();
      int wx, wy, ww, wh, hw, hh, m;
      m = $urandom_range(0, 99);
      if (m < 15) begin
         add_query($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end else begin
         ww = (m < 25) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
         wh = (m < 25) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
         hw = (m < 30) ? $urandom_range(0, 4095) : $urandom_range(0, 800);
         hh = (m < 30) ? $urandom_range(0, 4095) : $urandom_range(0, 800);
         wx = $signed(16'($urandom));
         wy = $signed(16'($urandom));
         add_query(wx + ww / 2 + $signed(13'($urandom)) * (ww / 2 + hw + hh + 8) / 4096,
                   wy + wh / 2 + $signed(13'($urandom)) * (wh / 2 + hw + hh + 8) / 4096,
                   $urandom, hw, hh, wx, wy, ww, wh);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
         sent <= 0;
         burst <= 1'b0;
      end else begin
         if (start && !busy) begin
            push_q.push_back(push_out(cur));
            sent <= sent + 1;
         end
         if (!(start && busy)) begin
            if (query_q.size() != 0 && gap == 0 &&
                !(sent + (start ? 1 : 0) == n_directed && push_q.size() != 0)) begin
               cur = query_q.pop_front();
               start <= 1'b1;
               req_pos_x <= cur.pos_x;
               req_pos_y <= cur.pos_y;
               req_angle_code <= cur.angle_code;
               req_half_width <= cur.half_width;
               req_half_height <= cur.half_height;
               req_wall_x <= cur.wall_x;
               req_wall_y <= cur.wall_y;
               req_wall_width <= cur.wall_width;
               req_wall_height <= cur.wall_height;
               if ($urandom_range(0, 49) == 0) burst <= !burst;
               gap <= burst ? 0 : $urandom_range(0, 12);
            end else begin
               start <= 1'b0;
               if (gap > 0) gap <= gap - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      push_out_type e;
      if (!reset && rsp_valid) begin
         got <= got + 1;
         if (push_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat at %0t", $realtime);
         end else begin
            e = push_q.pop_front();
            if (e.collided) begin
               n_hit++;
               axis_seen[e.min_axis]++;
            end
            if (rsp_new_x !== e.new_x || rsp_new_y !== e.new_y ||
                rsp_collided !== e.collided || rsp_min_axis !== e.min_axis ||
                rsp_push_depth !== e.push_depth) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch beat %0d: exp x=%0d y=%0d hit=%0b ax=%0d d=%0d",
                           got, e.new_x, e.new_y, e.collided, e.min_axis, e.push_depth);
                  $display("                 got x=%0d y=%0d hit=%0b ax=%0d d=%0d",
                           rsp_new_x, rsp_new_y, rsp_collided, rsp_min_axis,
                           rsp_push_depth);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall <= 0;
      end else if (stall >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall <= stall + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_angle_code = '0;
      req_half_width = '0;
      req_half_height = '0;
      req_wall_x = '0;
      req_wall_y = '0;
      req_wall_width = '0;
      req_wall_height = '0;
      errors = 0;
      got = 0;
      n_hit = 0;
      axis_seen = '{0, 0, 0, 0};
      add_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_query(32767, 32767, 1023, 4095, 4095, 32767, 32767, 65535, 65535);
      add_query(-32768, -32768, 512, 4095, 4095, -32768, -32768, 65535, 65535);
      add_query(800, 800, 0, 160, 160, 0, 0, 1600, 1600);
      add_query(800, 800, 128, 160, 160, 0, 0, 1600, 1600);
      add_query(800, 790, 0, 100, 40, 0, 0, 1600, 1600);
      add_query(-200, 100, 256, 100, 100, 0, 0, 1600, 1600);
      add_query(1700, 100, 768, 100, 100, 0, 0, 1600, 1600);
      add_query(-100, 100, 0, 100, 100, 0, 0, 1600, 1600);
      add_query(-99, 100, 0, 100, 100, 0, 0, 1600, 1600);
      add_query(-99, 100, 37, 100, 100, 0, 0, 1600, 1600);
      add_query(32760, 0, 0, 2000, 2000, 32000, -500, 700, 1000);
      add_query(-32760, 0, 512, 2000, 2000, -32768, -500, 700, 1000);
      add_query(0, 32767, 300, 4095, 100, -4000, 32000, 8000, 767);
      add_query(0, 0, 85, 4095, 4095, -32768, -32768, 65535, 65535);
      add_query(5000, -5000, 640, 1, 0, 4000, -6000, 2000, 2000);
      add_query(100, 100, 900, 50, 70, 100, 100, 0, 0);
      add_query(30000, 30000, 170, 3000, 3000, 32767, 32767, 65535, 65535);
      n_directed = query_q.size();
      for (int i = 0; i < N_RANDOM; i++) begin
         add_random_query();
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (query_q.size() == 0);
      @(posedge clock);
      while (start || push_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d queries, %0d results, %0d hits (axes %0d/%0d/%0d/%0d)",
               sent, got, n_hit, axis_seen[0], axis_seen[1], axis_seen[2],
               axis_seen[3]);
      $display("%0d mismatches", errors);
      if (errors == 0 && push_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/oasp_pkg.sv
rtl/oasp_trig.sv
rtl/oasp_proj.sv
rtl/oasp_sel.sv
rtl/oasp_push.sv
rtl/obb_aabb_sat_push_out_unit.sv
sim/tb_obb_aabb_sat_push_out_unit.sv
